// ===== rtl/kmp_pkg.sv =====
// kmp_pkg: sizes, opcodes and store interface types for the KMP stream matcher.
// Used by kmp_store and kmp_stream_matcher; no dependencies.
`timescale 1ns / 1ps
package kmp_pkg;

	localparam int MAX_PATTERN   = 64;
	localparam int SYMBOL_BITS   = 8;
	localparam int POSITION_BITS = 32;

	// failure store index covers 0..MAX_PATTERN, pattern store 0..MAX_PATTERN-1
	localparam int FIDX_BITS = $clog2(MAX_PATTERN + 1);
	localparam int PIDX_BITS = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	// prefix pointer: two's complement, holds -1..MAX_PATTERN
	localparam int PTR_BITS  = FIDX_BITS + 1;

	// fixed field widths at the ports
	localparam int OPCODE_BITS  = 2;
	localparam int SYM_IN_BITS  = 8;
	localparam int START_BITS   = 32;
	localparam int LEN_OUT_BITS = 7;
	localparam int S_DATA_BITS  = 8;
	localparam int M_DATA_BITS  = 48;

	typedef enum logic [OPCODE_BITS-1:0] {
		OP_CLEAR  = 2'd0,
		OP_APPEND = 2'd1,
		OP_TEXT   = 2'd2,
		OP_NOP    = 2'd3
	} opcode_t;

	typedef struct packed {
		logic                   pat_we;
		logic [PIDX_BITS-1:0]   pat_waddr;
		logic [SYMBOL_BITS-1:0] pat_wdata;
		logic                   fail_we;
		logic [FIDX_BITS-1:0]   fail_waddr;
		logic [PTR_BITS-1:0]    fail_wdata;
		logic [FIDX_BITS-1:0]   rd_addr;
	} store_req_t;

	typedef struct packed {
		logic [SYMBOL_BITS-1:0] pat;
		logic [PTR_BITS-1:0]    fail;
	} store_rsp_t;

endpackage

// ===== rtl/kmp_store.sv =====
// kmp_store: pattern and failure-link memories, one shared read address, registered read.
// Depends on kmp_pkg. Failure entry zero is fixed at -1 and never stored.
`timescale 1ns / 1ps
module kmp_store import kmp_pkg::*; (
	input  logic       clk,
	input  store_req_t req,
	output store_rsp_t rsp
);

	logic [SYMBOL_BITS-1:0] pat_mem [MAX_PATTERN];
	logic [PTR_BITS-1:0]    fail_mem [MAX_PATTERN + 1];
	logic [SYMBOL_BITS-1:0] pat_rd_q;
	logic [PTR_BITS-1:0]    fail_rd_q;

	always_ff @(posedge clk) begin
		if (req.pat_we) begin
			pat_mem[req.pat_waddr] <= req.pat_wdata;
		end
		if (req.fail_we) begin
			fail_mem[req.fail_waddr] <= req.fail_wdata;
		end
		// index MAX_PATTERN is only used for a failure link; pattern data then ignored
		if (req.rd_addr < FIDX_BITS'(MAX_PATTERN)) begin
			pat_rd_q <= pat_mem[req.rd_addr[PIDX_BITS-1:0]];
		end
		if (req.rd_addr == '0) begin
			fail_rd_q <= '1;
		end else begin
			fail_rd_q <= fail_mem[req.rd_addr];
		end
	end

	assign rsp.pat  = pat_rd_q;
	assign rsp.fail = fail_rd_q;

endmodule

// ===== rtl/kmp_stream_matcher.sv =====
// kmp_stream_matcher: top level, transaction handshake and failure-walk sequencer.
// Depends on kmp_pkg and kmp_store.
`timescale 1ns / 1ps
// Streaming Knuth-Morris-Pratt matcher. Each input transaction carries an opcode
// in s_tuser (clear, append pattern symbol, text symbol) and a symbol in s_tdata,
// and yields exactly one output transaction. A text symbol that completes the
// pattern sets m_tuser and reports the occurrence start; overlapping matches are
// reported. Items are processed one at a time: clear, a refused append, the unused
// opcode and a text symbol on an empty pattern go straight to the result state; any
// other append or text symbol first walks the failure chain, making k symbol compares,
// plus a link fetch when a match completes. Each compare takes a read state and a
// test state because the pattern and failure memories share one registered read port.
// Amortized, k stays below two per text symbol. A finished result waits in the
// output register while the next transaction is accepted.
module kmp_stream_matcher import kmp_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [S_DATA_BITS-1:0] s_tdata,  // [7:0] symbol
	input  logic [OPCODE_BITS-1:0] s_tuser,  // [1:0] opcode
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [M_DATA_BITS-1:0] m_tdata,  // [31:0] match_start, [32] pattern_dropped,
	                                         // [33] position_saturated, [40:34] pattern_length
	output logic [0:0]             m_tuser   // [0] match_found
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_TEST,
		S_POST,
		S_LINK,
		S_DONE
	} state_t;

	localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

	state_t                   state_q;
	opcode_t                  op_q;
	logic [SYMBOL_BITS-1:0]   sym_q;
	logic [PTR_BITS-1:0]      j_q;
	logic [PTR_BITS-1:0]      build_q;
	logic [FIDX_BITS-1:0]     len_q;
	logic [FIDX_BITS-1:0]     matched_q;
	logic [POSITION_BITS-1:0] pos_q;
	logic [POSITION_BITS-1:0] before_q;
	logic                     found_q;
	logic                     drop_q;
	logic [START_BITS-1:0]    start_q;
	logic                     m_tvalid_q;
	logic [M_DATA_BITS-1:0]   m_tdata_q;
	logic                     m_found_q;

	store_req_t               req;
	store_rsp_t               rsp;

	logic                     s_accept;
	opcode_t                  in_op;
	logic [SYMBOL_BITS-1:0]   in_sym;
	logic                     store_full;
	logic [POSITION_BITS-1:0] len_m1;
	logic [POSITION_BITS-1:0] start_pos;
	logic                     out_free;

	assign s_tready   = (state_q == S_IDLE);
	assign s_accept   = s_tvalid && s_tready;
	assign in_op      = opcode_t'(s_tuser);
	assign in_sym     = s_tdata[SYMBOL_BITS-1:0];
	assign store_full = (len_q == FIDX_BITS'(MAX_PATTERN));
	assign out_free   = !m_tvalid_q || m_tready;

	assign len_m1    = POSITION_BITS'(len_q) - POSITION_BITS'(1);
	assign start_pos = (before_q >= len_m1) ? (before_q - len_m1) : '0;

	always_comb begin
		req            = '0;
		req.pat_we     = s_accept && (in_op == OP_APPEND) && !store_full;
		req.pat_waddr  = len_q[PIDX_BITS-1:0];
		req.pat_wdata  = in_sym;
		req.fail_we    = (state_q == S_POST) && (op_q == OP_APPEND);
		req.fail_waddr = len_q + FIDX_BITS'(1);
		req.fail_wdata = j_q;
		// chain step reads entry j; otherwise the link of the full pattern
		req.rd_addr    = (state_q == S_READ) ? j_q[FIDX_BITS-1:0] : len_q;
	end

	kmp_store u_store (
		.clk (clk),
		.req (req),
		.rsp (rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			op_q       <= OP_NOP;
			sym_q      <= '0;
			j_q        <= '0;
			build_q    <= '1;
			len_q      <= '0;
			matched_q  <= '0;
			pos_q      <= '0;
			before_q   <= '0;
			found_q    <= 1'b0;
			drop_q     <= 1'b0;
			start_q    <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			m_found_q  <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_accept) begin
						op_q    <= in_op;
						sym_q   <= in_sym;
						found_q <= 1'b0;
						drop_q  <= 1'b0;
						start_q <= '0;
						case (in_op)
							OP_CLEAR: begin
								len_q     <= '0;
								build_q   <= '1;
								matched_q <= '0;
								pos_q     <= '0;
								state_q   <= S_DONE;
							end
							OP_APPEND: begin
								if (store_full) begin
									drop_q  <= 1'b1;
									state_q <= S_DONE;
								end else if (build_q[PTR_BITS-1]) begin
									j_q     <= '0;
									state_q <= S_POST;
								end else begin
									j_q     <= build_q;
									state_q <= S_READ;
								end
							end
							OP_TEXT: begin
								before_q <= pos_q;
								if (pos_q != POS_MAX) begin
									pos_q <= pos_q + POSITION_BITS'(1);
								end
								if (len_q == '0) begin
									matched_q <= '0;
									state_q   <= S_DONE;
								end else begin
									j_q     <= PTR_BITS'(matched_q);
									state_q <= S_READ;
								end
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_READ: begin
					state_q <= S_TEST;
				end
				S_TEST: begin
					if (rsp.pat == sym_q) begin
						j_q     <= j_q + PTR_BITS'(1);
						state_q <= S_POST;
					end else if (rsp.fail[PTR_BITS-1]) begin
						// fell off the chain: restart at prefix length zero
						j_q     <= '0;
						state_q <= S_POST;
					end else begin
						j_q     <= rsp.fail;
						state_q <= S_READ;
					end
				end
				S_POST: begin
					if (op_q == OP_APPEND) begin
						build_q   <= j_q;
						len_q     <= len_q + FIDX_BITS'(1);
						matched_q <= '0;
						pos_q     <= '0;
						state_q   <= S_DONE;
					end else if (j_q[FIDX_BITS-1:0] == len_q) begin
						found_q <= 1'b1;
						start_q <= START_BITS'(start_pos);
						state_q <= S_LINK;
					end else begin
						matched_q <= j_q[FIDX_BITS-1:0];
						state_q   <= S_DONE;
					end
				end
				S_LINK: begin
					matched_q <= rsp.fail[FIDX_BITS-1:0];
					state_q   <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_found_q  <= found_q;
						m_tdata_q  <= M_DATA_BITS'({LEN_OUT_BITS'(len_q), (pos_q == POS_MAX),
							drop_q, start_q});
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = m_tdata_q;
	assign m_tuser[0] = m_found_q;

`ifndef ASSERT_OFF
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= FIDX_BITS'(MAX_PATTERN))
		else $error("pattern length beyond store capacity");

	a_matched_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> ((len_q == '0 && matched_q == '0) || matched_q < len_q))
		else $error("matched prefix not below pattern length");

	a_build_bound: assert property (@(posedge clk) disable iff (!arst_n)
		build_q[PTR_BITS-1] || (build_q[FIDX_BITS-1:0] < len_q))
		else $error("build pointer not below pattern length");

	a_pos_step: assert property (@(posedge clk) disable iff (!arst_n)
		(s_accept && in_op == OP_TEXT && pos_q != POS_MAX)
		|=> (pos_q == $past(pos_q) + POSITION_BITS'(1)))
		else $error("text position did not advance");

	a_found_text: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LINK) |-> (op_q == OP_TEXT && found_q))
		else $error("link fetch outside a completed match");
`endif

endmodule
